### rtl/wpf_pkg.sv
// ----------------------------------------------------------------------------
// wpf_pkg
// Shared types, sizes, register indexes and fp16/fp32 helpers for the
// window pooling unit.
// ----------------------------------------------------------------------------
package wpf_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int MAX_WINDOW = 8;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int SLOT_W   = $clog2(MAX_WINDOW);
    localparam int LS_DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int LS_AW    = $clog2(LS_DEPTH);
    localparam int LS_DW    = 17;

    localparam logic [15:0] FP16_NEG_INF = 16'hFC00;
    localparam logic [16:0] COUNT_LIMIT  = 17'h1FFFF;

    // configuration register indexes
    localparam logic [2:0] REG_POOL_KIND   = 3'd0;
    localparam logic [2:0] REG_GLOBAL_MODE = 3'd1;
    localparam logic [2:0] REG_EXCLUDE_PAD = 3'd2;
    localparam logic [2:0] REG_WIN_W       = 3'd3;
    localparam logic [2:0] REG_WIN_H       = 3'd4;
    localparam logic [2:0] REG_STEP_X      = 3'd5;
    localparam logic [2:0] REG_STEP_Y      = 3'd6;
    localparam logic [2:0] REG_MAP_W       = 3'd7;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
    } wpf_add_req_t;

    typedef struct packed {
        logic        start;
        logic [31:0] num;
        logic [16:0] den;
    } wpf_div_req_t;

    typedef struct packed {
        logic             we;
        logic [LS_AW-1:0] addr;
        logic [LS_DW-1:0] data;
    } wpf_ls_wr_t;

    // fp16 pattern to fp32 pattern, exact
    function automatic logic [31:0] h2f(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  k;
        logic [32:0] tmp;
        logic [31:0] f;
        ex  = h[14:10];
        man = h[9:0];
        k   = '0;
        tmp = '0;
        if (ex == 5'd0) begin
            if (man == 10'd0) begin
                f = {h[15], 31'b0};
            end else begin
                for (int i = 0; i < 10; i++) begin
                    if (man[i]) k = 4'(i);
                end
                tmp = {23'b0, man} << (5'd23 - {1'b0, k});
                f = {h[15], 8'd103 + {4'b0, k}, tmp[22:0]};
            end
        end else if (ex == 5'd31) begin
            f = {h[15], 8'hFF, man, 13'b0};
        end else begin
            f = {h[15], {3'b0, ex} + 8'd112, man, 13'b0};
        end
        return f;
    endfunction

    // fp32 pattern to fp16 pattern, round to nearest even
    function automatic logic [15:0] f2h(input logic [31:0] f);
        logic               s;
        logic [7:0]         ex;
        logic [22:0]        man;
        logic signed [9:0]  e;
        logic [9:0]         shv;
        logic [4:0]         sh;
        logic [23:0]        m24;
        logic [23:0]        half;
        logic [23:0]        rem;
        logic [23:0]        hw;
        logic [14:0]        hn;
        logic [12:0]        rn;
        logic [15:0]        r;
        s    = f[31];
        ex   = f[30:23];
        man  = f[22:0];
        e    = $signed({2'b0, ex}) - 10'sd112;
        shv  = '0;
        sh   = '0;
        m24  = {1'b1, man};
        half = '0;
        rem  = '0;
        hw   = '0;
        hn   = '0;
        rn   = '0;
        if (ex == 8'hFF) begin
            r = (man != 23'd0) ? {s, 15'h7E00 | {5'b0, man[22:13]}} : {s, 15'h7C00};
        end else if (e >= 10'sd31) begin
            r = {s, 15'h7C00};
        end else if (e <= 10'sd0) begin
            if (e < -10'sd10) begin
                r = {s, 15'b0};
            end else begin
                shv  = 10'(10'sd14 - e);
                sh   = shv[4:0];
                half = m24 >> sh;
                rem  = m24 & ((24'd1 << sh) - 24'd1);
                hw   = 24'd1 << (sh - 5'd1);
                if (rem > hw || (rem == hw && half[0])) half = half + 24'd1;
                r = {s, half[14:0]};
            end
        end else begin
            hn = {e[4:0], man[22:13]};
            rn = man[12:0];
            if (rn > 13'h1000 || (rn == 13'h1000 && hn[0])) hn = hn + 15'd1;
            r = {s, hn};
        end
        return r;
    endfunction

    // a < b as fp16 values; false when either is NaN
    function automatic logic lt16(input logic [15:0] a, input logic [15:0] b);
        logic an;
        logic bn;
        logic r;
        an = (&a[14:10]) && (|a[9:0]);
        bn = (&b[14:10]) && (|b[9:0]);
        if (an || bn) begin
            r = 1'b0;
        end else if (a[14:0] == 15'd0 && b[14:0] == 15'd0) begin
            r = 1'b0;
        end else begin
            case ({a[15], b[15]})
                2'b00:   r = a[14:0] < b[14:0];
                2'b01:   r = 1'b0;
                2'b10:   r = 1'b1;
                default: r = a[14:0] > b[14:0];
            endcase
        end
        return r;
    endfunction

endpackage

### rtl/window_pooling_fp16_unit.sv
// ----------------------------------------------------------------------------
// window_pooling_fp16_unit
// Streaming fp16 max/average pooling of one padded feature map.
// ----------------------------------------------------------------------------
// Pixels arrive in raster order and are written to a line store of the last
// eight rows. One pixel is taken at a time: each pixel passes the shared
// fp32 adder for the global sum, then an 8-step division that yields the
// window indices. A pixel that closes a window then reads each window pixel
// from the line store in turn, and a pixel that is counted also passes the
// adder, since each fp32 add waits on the last one; an average then goes
// through the bit-serial divider. After reset the line store is cleared,
// during which no pixel is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module window_pooling_fp16_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    // pixel requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // pixel
    input  logic        s_tuser,   // is_padding
    input  logic        s_tlast,   // map_end
    // pooled results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // pooled, out_row, out_col
    output logic        m_tuser,   // empty_window
    output logic        m_tlast    // last_output
);
    import wpf_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_GADD   = 4'd1;
    localparam logic [3:0] S_IDX    = 4'd2;
    localparam logic [3:0] S_DECIDE = 4'd3;
    localparam logic [3:0] S_RD     = 4'd4;
    localparam logic [3:0] S_DAT    = 4'd5;
    localparam logic [3:0] S_AW     = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    logic [3:0]  state_reg;
    logic [3:0]  state_next;

    logic        pool_kind_reg;
    logic        global_mode_reg;
    logic        exclude_pad_reg;
    logic [3:0]  win_w_reg;
    logic [3:0]  win_h_reg;
    logic [3:0]  step_x_reg;
    logic [3:0]  step_y_reg;
    logic [8:0]  map_w_reg;

    logic [COL_W-1:0] col_cnt_reg;
    logic [7:0]  row_cnt_reg;
    logic [31:0] global_sum_reg;
    logic [15:0] global_max_reg;
    logic [16:0] global_cnt_reg;

    logic        end_reg;
    logic [COL_W-1:0] c_reg;
    logic [7:0]  r_reg;
    logic [7:0]  rq_reg;
    logic [3:0]  rr_reg;
    logic [7:0]  cq_reg;
    logic [3:0]  cr_reg;
    logic [2:0]  step_cnt_reg;
    logic [2:0]  wi_reg;
    logic [2:0]  wj_reg;
    logic [15:0] wmax_reg;
    logic [31:0] wsum_reg;
    logic [6:0]  area_reg;
    logic [15:0] res_reg;
    logic        empty_reg;

    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic        m_user_reg;
    logic        m_last_reg;

    logic [3:0]  kw;
    logic [3:0]  kh;
    logic [3:0]  sx;
    logic [3:0]  sy;
    logic [8:0]  mw;
    logic [8:0]  mw_m1;
    logic [COL_W-1:0] c_cur;
    logic [8:0]  c_inc;
    logic [7:0]  rbase;
    logic [7:0]  cbase;
    logic        row_ok;
    logic        col_ok;
    logic        hit;
    logic        accept;
    logic        counted;
    logic        last_elem;
    logic        out_free;
    logic [4:0]  rt;
    logic [4:0]  ct;
    logic [SLOT_W-1:0] rd_slot;
    logic [COL_W-1:0]  rd_col;

    wpf_ls_wr_t       ls_wr;
    logic [LS_AW-1:0] ls_rd_addr;
    logic [LS_DW-1:0] ls_rd_data;
    logic             ls_busy;
    wpf_add_req_t     add_req;
    logic [31:0]      add_sum;
    wpf_div_req_t     div_req;
    logic             div_done;
    logic [31:0]      div_quot;

    // register values clamped to their working range
    always_comb begin
        kw = (win_w_reg == 4'd0) ? 4'd1 : (win_w_reg > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW)
                                                                      : win_w_reg;
        kh = (win_h_reg == 4'd0) ? 4'd1 : (win_h_reg > 4'(MAX_WINDOW)) ? 4'(MAX_WINDOW)
                                                                      : win_h_reg;
        sx = (step_x_reg == 4'd0) ? 4'd1 : step_x_reg;
        sy = (step_y_reg == 4'd0) ? 4'd1 : step_y_reg;
        mw = (map_w_reg == 9'd0) ? 9'd1 : (map_w_reg > 9'(MAX_WIDTH)) ? 9'(MAX_WIDTH)
                                                                      : map_w_reg;
        mw_m1 = mw - 9'd1;
    end

    // current column and window origin
    always_comb begin
        c_cur  = ({1'b0, col_cnt_reg} >= mw) ? mw_m1[COL_W-1:0] : col_cnt_reg;
        c_inc  = {1'b0, c_cur} + 9'd1;
        rbase  = r_reg + 8'd1 - {4'b0, kh};
        cbase  = c_reg + 8'd1 - {4'b0, kw};
        row_ok = ({1'b0, r_reg} + 9'd1) >= {5'b0, kh};
        col_ok = ({1'b0, c_reg} + 9'd1) >= {5'b0, kw};
        hit    = !global_mode_reg && row_ok && col_ok && rr_reg == 4'd0 && cr_reg == 4'd0;
        accept = s_tvalid && s_tready;
        counted   = !exclude_pad_reg || !ls_rd_data[16];
        last_elem = ({1'b0, wj_reg} == kw - 4'd1) && ({1'b0, wi_reg} == kh - 4'd1);
        out_free  = !m_valid_reg || m_tready;
        rt = {rr_reg, rq_reg[7]};
        ct = {cr_reg, cq_reg[7]};
        rd_slot = rbase[SLOT_W-1:0] + wi_reg;
        rd_col  = cbase + {5'b0, wj_reg};
    end

    assign s_tready = (state_reg == S_IDLE) && !ls_busy;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // line store ports
    assign ls_wr.we    = accept;
    assign ls_wr.addr  = {row_cnt_reg[SLOT_W-1:0], c_cur};
    assign ls_wr.data  = {s_tuser, s_tdata};
    assign ls_rd_addr  = {rd_slot, rd_col};

    // adder shared by the global sum and the window sum
    assign add_req.a = (state_reg == S_IDLE) ? global_sum_reg : wsum_reg;
    assign add_req.b = (state_reg == S_IDLE) ? h2f(s_tdata) : h2f(ls_rd_data[15:0]);

    // divider start for a global or a window average
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = wsum_reg;
        div_req.den   = {10'b0, area_reg};
        if (state_reg == S_DECIDE) begin
            div_req.start = global_mode_reg && end_reg && pool_kind_reg;
            div_req.num   = global_sum_reg;
            div_req.den   = global_cnt_reg;
        end else if (state_reg == S_FIN) begin
            div_req.start = pool_kind_reg && area_reg != 7'd0;
        end
    end

    wpf_line_store u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (ls_wr),
        .rd_addr (ls_rd_addr),
        .rd_data (ls_rd_data),
        .busy    (ls_busy)
    );

    wpf_fp32_add u_add (
        .aclk (aclk),
        .req  (add_req),
        .sum  (add_sum)
    );

    wpf_fp32_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .quot    (div_quot)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (accept) state_next = S_GADD;
            S_GADD:   state_next = S_IDX;
            S_IDX:    if (step_cnt_reg == 3'd7) state_next = S_DECIDE;
            S_DECIDE: begin
                if (global_mode_reg) begin
                    if (end_reg) state_next = pool_kind_reg ? S_DIV : S_EMIT;
                    else state_next = S_IDLE;
                end else begin
                    state_next = hit ? S_RD : S_IDLE;
                end
            end
            S_RD:     state_next = S_DAT;
            S_DAT: begin
                if (counted) state_next = S_AW;
                else state_next = last_elem ? S_FIN : S_RD;
            end
            S_AW:     state_next = last_elem ? S_FIN : S_RD;
            S_FIN:    state_next = (pool_kind_reg && area_reg != 7'd0) ? S_DIV : S_EMIT;
            S_DIV:    if (div_done) state_next = S_EMIT;
            S_EMIT:   if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // control state, configuration, counters and global reductions
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            pool_kind_reg   <= 1'b0;
            global_mode_reg <= 1'b0;
            exclude_pad_reg <= 1'b0;
            win_w_reg       <= 4'd2;
            win_h_reg       <= 4'd2;
            step_x_reg      <= 4'd2;
            step_y_reg      <= 4'd2;
            map_w_reg       <= 9'd1;
            col_cnt_reg     <= '0;
            row_cnt_reg     <= '0;
            global_sum_reg  <= '0;
            global_max_reg  <= FP16_NEG_INF;
            global_cnt_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            // configuration writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_POOL_KIND:   pool_kind_reg   <= cfg_data[0];
                    REG_GLOBAL_MODE: global_mode_reg <= cfg_data[0];
                    REG_EXCLUDE_PAD: exclude_pad_reg <= cfg_data[0];
                    REG_WIN_W:       win_w_reg       <= cfg_data[3:0];
                    REG_WIN_H:       win_h_reg       <= cfg_data[3:0];
                    REG_STEP_X:      step_x_reg      <= cfg_data[3:0];
                    REG_STEP_Y:      step_y_reg      <= cfg_data[3:0];
                    REG_MAP_W:       map_w_reg       <= cfg_data;
                    default: ;
                endcase
            end
            // raster position and running map reductions
            if (accept) begin
                if (s_tlast) begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= '0;
                end else if (c_inc >= mw) begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= row_cnt_reg + 8'd1;
                end else begin
                    col_cnt_reg <= c_inc[COL_W-1:0];
                end
                if (lt16(global_max_reg, s_tdata)) global_max_reg <= s_tdata;
                if (global_cnt_reg != COUNT_LIMIT) global_cnt_reg <= global_cnt_reg + 17'd1;
            end
            if (state_reg == S_GADD) global_sum_reg <= add_sum;
            // map end returns the reductions to their start values
            if (state_reg == S_DECIDE && end_reg) begin
                global_sum_reg <= '0;
                global_max_reg <= FP16_NEG_INF;
                global_cnt_reg <= '0;
            end
            // output register
            if (state_reg == S_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // per-pixel datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                end_reg <= s_tlast;
                c_reg   <= c_cur;
                r_reg   <= row_cnt_reg;
            end
            S_GADD: begin
                rq_reg       <= rbase;
                rr_reg       <= '0;
                cq_reg       <= cbase;
                cr_reg       <= '0;
                step_cnt_reg <= '0;
            end
            S_IDX: begin
                // one restoring step for row and column indices
                step_cnt_reg <= step_cnt_reg + 3'd1;
                if (rt >= {1'b0, sy}) begin
                    rr_reg <= 4'(rt - {1'b0, sy});
                    rq_reg <= {rq_reg[6:0], 1'b1};
                end else begin
                    rr_reg <= rt[3:0];
                    rq_reg <= {rq_reg[6:0], 1'b0};
                end
                if (ct >= {1'b0, sx}) begin
                    cr_reg <= 4'(ct - {1'b0, sx});
                    cq_reg <= {cq_reg[6:0], 1'b1};
                end else begin
                    cr_reg <= ct[3:0];
                    cq_reg <= {cq_reg[6:0], 1'b0};
                end
            end
            S_DECIDE: begin
                wi_reg    <= '0;
                wj_reg    <= '0;
                wmax_reg  <= FP16_NEG_INF;
                wsum_reg  <= '0;
                area_reg  <= '0;
                res_reg   <= global_max_reg;
                empty_reg <= 1'b0;
            end
            S_DAT: begin
                if (lt16(wmax_reg, ls_rd_data[15:0])) wmax_reg <= ls_rd_data[15:0];
                if (counted) area_reg <= area_reg + 7'd1;
                if (!counted) begin
                    if ({1'b0, wj_reg} == kw - 4'd1) begin
                        wj_reg <= '0;
                        wi_reg <= wi_reg + 3'd1;
                    end else begin
                        wj_reg <= wj_reg + 3'd1;
                    end
                end
            end
            S_AW: begin
                wsum_reg <= add_sum;
                if ({1'b0, wj_reg} == kw - 4'd1) begin
                    wj_reg <= '0;
                    wi_reg <= wi_reg + 3'd1;
                end else begin
                    wj_reg <= wj_reg + 3'd1;
                end
            end
            S_FIN: begin
                if (!pool_kind_reg) begin
                    res_reg <= wmax_reg;
                end else if (area_reg == 7'd0) begin
                    res_reg   <= '0;
                    empty_reg <= 1'b1;
                end
            end
            S_DIV: begin
                if (div_done) res_reg <= f2h(div_quot);
            end
            S_EMIT: begin
                if (out_free) begin
                    m_data_reg <= global_mode_reg ? {16'b0, res_reg}
                                                  : {cq_reg, rq_reg, res_reg};
                    m_user_reg <= empty_reg;
                    m_last_reg <= end_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

### rtl/wpf_line_store.sv
// ----------------------------------------------------------------------------
// wpf_line_store
// Line store of the last rows of the map, one write and one registered read
// port, with a clearing sweep after reset.
// ----------------------------------------------------------------------------
module wpf_line_store (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  wpf_pkg::wpf_ls_wr_t         wr,
    input  logic [wpf_pkg::LS_AW-1:0]   rd_addr,
    output logic [wpf_pkg::LS_DW-1:0]   rd_data,
    output logic                        busy
);
    import wpf_pkg::*;

    logic [LS_DW-1:0] mem [LS_DEPTH];
    logic [LS_AW:0]   clr_cnt_reg;
    logic [LS_DW-1:0] rd_data_reg;

    assign busy    = ~clr_cnt_reg[LS_AW];
    assign rd_data = rd_data_reg;

    // clearing sweep counter, top bit set when done
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (busy) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // storage write and registered read
    always_ff @(posedge aclk) begin
        if (busy) begin
            mem[clr_cnt_reg[LS_AW-1:0]] <= '0;
        end else if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

### rtl/wpf_fp32_add.sv
// ----------------------------------------------------------------------------
// wpf_fp32_add
// Two-stage fp32 adder: align and add, then normalize and round to nearest
// even. The sum is valid in the cycle after the request.
// ----------------------------------------------------------------------------
module wpf_fp32_add (
    input  logic                  aclk,
    input  wpf_pkg::wpf_add_req_t req,
    output logic [31:0]           sum
);
    import wpf_pkg::*;

    typedef struct packed {
        logic        spec;
        logic [31:0] spec_val;
        logic        sgn;
        logic [7:0]  ex;
        logic [27:0] mag;
    } add_mid_t;

    add_mid_t    mid_next;
    add_mid_t    mid_reg;
    logic [31:0] big;
    logic [31:0] sml;
    logic [7:0]  d;
    logic [26:0] mb;
    logic [26:0] ms;
    logic [26:0] shf;
    logic [26:0] mask;
    logic        stk;
    logic        a_nan;
    logic        b_nan;
    logic        a_inf;
    logic        b_inf;
    logic        a_zero;
    logic        b_zero;

    // stage one: operand classes, alignment and add
    always_comb begin
        a_nan  = (&req.a[30:23]) && (|req.a[22:0]);
        b_nan  = (&req.b[30:23]) && (|req.b[22:0]);
        a_inf  = (&req.a[30:23]) && ~(|req.a[22:0]);
        b_inf  = (&req.b[30:23]) && ~(|req.b[22:0]);
        a_zero = ~(|req.a[30:0]);
        b_zero = ~(|req.b[30:0]);
        big    = req.a;
        sml    = req.b;
        if (req.b[30:0] > req.a[30:0]) begin
            big = req.b;
            sml = req.a;
        end
        d    = big[30:23] - sml[30:23];
        mb   = {1'b1, big[22:0], 3'b0};
        ms   = {1'b1, sml[22:0], 3'b0};
        mask = '0;
        stk  = 1'b0;
        if (d >= 8'd27) begin
            shf = 27'd1;
        end else begin
            mask = (27'd1 << d) - 27'd1;
            stk  = |(ms & mask);
            shf  = (ms >> d) | {26'b0, stk};
        end
        mid_next          = '0;
        mid_next.sgn      = big[31];
        mid_next.ex       = big[30:23];
        mid_next.mag      = (big[31] == sml[31]) ? ({1'b0, mb} + {1'b0, shf})
                                                 : ({1'b0, mb} - {1'b0, shf});
        if (a_nan) begin
            mid_next.spec     = 1'b1;
            mid_next.spec_val = req.a | 32'h0040_0000;
        end else if (b_nan) begin
            mid_next.spec     = 1'b1;
            mid_next.spec_val = req.b | 32'h0040_0000;
        end else if (a_inf && b_inf && (req.a[31] != req.b[31])) begin
            mid_next.spec     = 1'b1;
            mid_next.spec_val = 32'hFFC0_0000;
        end else if (a_inf) begin
            mid_next.spec     = 1'b1;
            mid_next.spec_val = req.a;
        end else if (b_inf) begin
            mid_next.spec     = 1'b1;
            mid_next.spec_val = req.b;
        end else if (a_zero && b_zero) begin
            mid_next.spec     = 1'b1;
            mid_next.spec_val = {req.a[31] & req.b[31], 31'b0};
        end else if (a_zero) begin
            mid_next.spec     = 1'b1;
            mid_next.spec_val = req.b;
        end else if (b_zero) begin
            mid_next.spec     = 1'b1;
            mid_next.spec_val = req.a;
        end
    end

    always_ff @(posedge aclk) begin
        mid_reg <= mid_next;
    end

    logic [26:0] nm;
    logic [4:0]  lz;
    logic [9:0]  e;
    logic [24:0] rnd;
    logic [22:0] frac;
    logic        up;

    // stage two: normalize and round
    always_comb begin
        lz = '0;
        for (int k = 0; k < 27; k++) begin
            if (mid_reg.mag[k]) lz = 5'(26 - k);
        end
        if (mid_reg.mag[27]) begin
            nm = mid_reg.mag[27:1] | {26'b0, mid_reg.mag[0]};
            e  = {2'b0, mid_reg.ex} + 10'd1;
        end else begin
            nm = mid_reg.mag[26:0] << lz;
            e  = {2'b0, mid_reg.ex} - {5'b0, lz};
        end
        up  = nm[2] && (nm[1] || nm[0] || nm[3]);
        rnd = {1'b0, nm[26:3]} + {24'b0, up};
        if (rnd[24]) begin
            e    = e + 10'd1;
            frac = rnd[23:1];
        end else begin
            frac = rnd[22:0];
        end
        if (mid_reg.spec) begin
            sum = mid_reg.spec_val;
        end else if (mid_reg.mag == 28'd0) begin
            sum = '0;
        end else if (e >= 10'd255) begin
            sum = {mid_reg.sgn, 8'hFF, 23'b0};
        end else begin
            sum = {mid_reg.sgn, e[7:0], frac};
        end
    end

endmodule

### rtl/wpf_fp32_div.sv
// ----------------------------------------------------------------------------
// wpf_fp32_div
// Divides an fp32 value by a positive integer count, one quotient bit per
// cycle, rounded to nearest even fp32.
// ----------------------------------------------------------------------------
module wpf_fp32_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wpf_pkg::wpf_div_req_t req,
    output logic                  done,
    output logic [31:0]           quot
);
    import wpf_pkg::*;

    localparam logic [1:0] D_IDLE  = 2'd0;
    localparam logic [1:0] D_PREP  = 2'd1;
    localparam logic [1:0] D_ITER  = 2'd2;
    localparam logic [1:0] D_ROUND = 2'd3;

    logic [1:0]  state_reg;
    logic [4:0]  cnt_reg;
    logic        done_reg;
    logic [31:0] num_reg;
    logic [16:0] den_reg;
    logic [23:0] mb_reg;
    logic [25:0] rem_reg;
    logic [25:0] q_reg;
    logic [9:0]  e_reg;
    logic [31:0] quot_reg;

    logic [4:0]  k;
    logic [40:0] mb_wide;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [24:0] m25;
    logic        up;
    logic [9:0]  e_fin;

    assign done = done_reg;
    assign quot = quot_reg;

    // divisor normalization and final rounding
    always_comb begin
        k = '0;
        for (int i = 0; i < 17; i++) begin
            if (den_reg[i]) k = 5'(i);
        end
        mb_wide = {24'b0, den_reg} << (5'd23 - k);
        mb      = mb_wide[23:0];
        ma      = {1'b1, num_reg[22:0]};
        up      = q_reg[1] && (q_reg[0] || (rem_reg != 26'd0) || q_reg[2]);
        m25     = {1'b0, q_reg[25:2]} + {24'b0, up};
        e_fin   = m25[24] ? e_reg + 10'd1 : e_reg;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE: begin
                    if (req.start) state_reg <= D_PREP;
                end
                D_PREP: begin
                    cnt_reg <= '0;
                    if ((&num_reg[30:23]) || ~(|num_reg[30:0])) begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end else begin
                        state_reg <= D_ITER;
                    end
                end
                D_ITER: begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd25) state_reg <= D_ROUND;
                end
                D_ROUND: begin
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default: state_reg <= D_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            D_IDLE: begin
                num_reg <= req.num;
                den_reg <= req.den;
            end
            D_PREP: begin
                mb_reg <= mb;
                q_reg  <= '0;
                // NaN is quieted, infinity and zero pass through
                if ((&num_reg[30:23]) && (|num_reg[22:0])) begin
                    quot_reg <= num_reg | 32'h0040_0000;
                end else begin
                    quot_reg <= num_reg;
                end
                if (ma < mb) begin
                    rem_reg <= {1'b0, ma, 1'b0};
                    e_reg   <= {2'b0, num_reg[30:23]} - {5'b0, k} - 10'd1;
                end else begin
                    rem_reg <= {2'b0, ma};
                    e_reg   <= {2'b0, num_reg[30:23]} - {5'b0, k};
                end
            end
            D_ITER: begin
                if (rem_reg >= {2'b0, mb_reg}) begin
                    q_reg   <= {q_reg[24:0], 1'b1};
                    rem_reg <= {rem_reg[24:0] - {1'b0, mb_reg}, 1'b0};
                end else begin
                    q_reg   <= {q_reg[24:0], 1'b0};
                    rem_reg <= {rem_reg[24:0], 1'b0};
                end
            end
            D_ROUND: begin
                quot_reg <= {num_reg[31], e_fin[7:0],
                             m25[24] ? m25[23:1] : m25[22:0]};
            end
            default: ;
        endcase
    end

endmodule

### tb/sv/pool_checker.sv
// ----------------------------------------------------------------------------
// pool_checker
// Watches the configuration port and both stream channels of the window
// pooling unit, keeps its own line store and counters, works out the pooled
// result of every pixel request and compares it with what the unit sends.
// ----------------------------------------------------------------------------
module pool_checker
    import wpf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // pixel
    input  logic        s_tuser,   // is_padding
    input  logic        s_tlast,   // map_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // pooled, out_row, out_col
    input  logic        m_tuser,   // empty_window
    input  logic        m_tlast,   // last_output
    output int          fail_count,
    output int          waiting,
    output int          result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] value;
        logic [7:0]  row;
        logic [7:0]  col;
        logic        empty;
        logic        last;
    } pooled_t;

    pooled_t pooled_q[$];

    // register copies
    logic       avg_mode;
    logic       glob_mode;
    logic       skip_pad;
    logic [3:0] win_w;
    logic [3:0] win_h;
    logic [3:0] stride_x;
    logic [3:0] stride_y;
    logic [8:0] map_w;

    // state of the pooling unit
    logic [16:0] rows_mem [MAX_WINDOW][MAX_WIDTH];
    int          col_cnt;
    int          row_cnt;
    real         map_sum;
    logic [15:0] map_max;
    logic [16:0] map_cnt;

    initial begin
        fail_count   = 0;
        result_count = 0;
        waiting      = 0;
    end

    // fp16 pattern as a real, exact
    function automatic real half_val(input logic [15:0] h);
        real v;
        if (h[14:10] == 5'd0) begin
            v = real'(h[9:0]) / 16777216.0;
            if (h[15]) v = -v;
        end else if (h[14:10] == 5'd31) begin
            v = $bitstoreal({h[15], 11'h7FF, h[9:0] != 10'd0, 51'b0});
        end else begin
            v = $bitstoreal({h[15], 11'(h[14:10] + 11'd1008), h[9:0], 42'b0});
        end
        return v;
    endfunction

    // round a real to the nearest fp32 value, ties to even
    function automatic real to_single(input real x);
        logic [63:0] b;
        logic [33:0] keep;
        logic [28:0] rest;
        b = $realtobits(x);
        if (b[62:52] == 11'h7FF || b[62:0] == 63'd0) return x;
        keep = {b[62:52], b[51:29]};
        rest = b[28:0];
        if (rest > 29'h1000_0000 || (rest == 29'h1000_0000 && keep[0])) keep = keep + 34'd1;
        return $bitstoreal({b[63], keep, 29'b0});
    endfunction

    // real to fp16 pattern, ties to even
    function automatic logic [15:0] half_bits(input real x);
        logic [63:0] b;
        logic [14:0] hn;
        logic [41:0] rest;
        logic [63:0] m;
        logic [63:0] q;
        logic [63:0] rq;
        logic [63:0] hw;
        int          e;
        int          sh;
        b = $realtobits(x);
        e = int'(b[62:52]) - 1023;
        if (b[62:52] == 11'h7FF) return (b[51:0] != 0) ? {b[63], 15'h7E00} : {b[63], 15'h7C00};
        if (b[62:0] == 63'd0) return {b[63], 15'd0};
        if (e >= 16) return {b[63], 15'h7C00};
        if (e >= -14) begin
            hn   = {5'(e + 15), b[51:42]};
            rest = b[41:0];
            if (rest > 42'h200_0000_0000 || (rest == 42'h200_0000_0000 && hn[0])) hn = hn + 15'd1;
            return {b[63], hn};
        end
        if (e < -25) return {b[63], 15'd0};
        // below the fp16 normal range
        sh = 28 - e;
        m  = {11'd1, b[51:0]};
        q  = m >> sh;
        rq = m & ((64'd1 << sh) - 64'd1);
        hw = 64'd1 << (sh - 1);
        if (rq > hw || (rq == hw && q[0])) q = q + 64'd1;
        return {b[63], q[14:0]};
    endfunction

    function automatic bit is_nan16(input logic [15:0] h);
        return (&h[14:10]) && (|h[9:0]);
    endfunction

    function automatic int clamp_size(input int v, input int hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // work out the result of one accepted pixel
    task automatic pool_pixel(input logic [15:0] pix, input logic pad, input logic at_end);
        int          kw;
        int          kh;
        int          sx;
        int          sy;
        int          mw;
        int          c;
        int          r;
        int          area;
        int          slot;
        logic [15:0] mx;
        logic [16:0] ent;
        real         sum;
        pooled_t     res;
        kw = clamp_size(win_w, MAX_WINDOW);
        kh = clamp_size(win_h, MAX_WINDOW);
        sx = (stride_x == 0) ? 1 : stride_x;
        sy = (stride_y == 0) ? 1 : stride_y;
        mw = clamp_size(map_w, MAX_WIDTH);
        c  = col_cnt;
        r  = row_cnt;
        if (c >= mw) c = mw - 1;
        rows_mem[r % MAX_WINDOW][c] = {pad, pix};

        // whole-map reductions always run
        map_sum = to_single(map_sum + half_val(pix));
        if (half_val(map_max) < half_val(pix)) map_max = pix;
        if (map_cnt < COUNT_LIMIT) map_cnt = map_cnt + 17'd1;

        if (glob_mode) begin
            if (at_end) begin
                res.value = avg_mode ? half_bits(to_single(map_sum / real'(map_cnt))) : map_max;
                res.row   = '0;
                res.col   = '0;
                res.empty = 1'b0;
                res.last  = 1'b1;
                pooled_q.push_back(res);
            end
        end else if (r + 1 >= kh && (r + 1 - kh) % sy == 0 &&
                     c + 1 >= kw && (c + 1 - kw) % sx == 0) begin
            mx   = FP16_NEG_INF;
            area = 0;
            sum  = 0.0;
            for (int i = 0; i < kh; i++) begin
                slot = (r + 1 - kh + i) % MAX_WINDOW;
                for (int j = 0; j < kw; j++) begin
                    ent = rows_mem[slot][c + 1 - kw + j];
                    if (half_val(mx) < half_val(ent[15:0])) mx = ent[15:0];
                    if (!skip_pad || !ent[16]) begin
                        sum  = to_single(sum + half_val(ent[15:0]));
                        area = area + 1;
                    end
                end
            end
            res.empty = 1'b0;
            if (!avg_mode) begin
                res.value = mx;
            end else if (area == 0) begin
                res.value = '0;
                res.empty = 1'b1;
            end else begin
                res.value = half_bits(to_single(sum / real'(skip_pad ? area : kw * kh)));
            end
            res.row  = 8'((r + 1 - kh) / sy);
            res.col  = 8'((c + 1 - kw) / sx);
            res.last = at_end;
            pooled_q.push_back(res);
        end

        // advance the raster position
        if (at_end) begin
            col_cnt = 0;
            row_cnt = 0;
            map_sum = 0.0;
            map_max = FP16_NEG_INF;
            map_cnt = '0;
        end else if (c + 1 >= mw) begin
            col_cnt = 0;
            row_cnt = (r + 1 >= MAX_HEIGHT) ? 0 : r + 1;
        end else begin
            col_cnt = c + 1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count = fail_count + 1;
    endtask

    always @(posedge aclk) begin
        pooled_t want;
        if (!aresetn) begin
            avg_mode  = 1'b0;
            glob_mode = 1'b0;
            skip_pad  = 1'b0;
            win_w     = 4'd2;
            win_h     = 4'd2;
            stride_x  = 4'd2;
            stride_y  = 4'd2;
            map_w     = 9'd1;
            for (int i = 0; i < MAX_WINDOW; i++) begin
                for (int j = 0; j < MAX_WIDTH; j++) rows_mem[i][j] = '0;
            end
            col_cnt = 0;
            row_cnt = 0;
            map_sum = 0.0;
            map_max = FP16_NEG_INF;
            map_cnt = '0;
            pooled_q.delete();
        end else begin
            // register writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_POOL_KIND:   avg_mode  = cfg_data[0];
                    REG_GLOBAL_MODE: glob_mode = cfg_data[0];
                    REG_EXCLUDE_PAD: skip_pad  = cfg_data[0];
                    REG_WIN_W:       win_w     = cfg_data[3:0];
                    REG_WIN_H:       win_h     = cfg_data[3:0];
                    REG_STEP_X:      stride_x  = cfg_data[3:0];
                    REG_STEP_Y:      stride_y  = cfg_data[3:0];
                    REG_MAP_W:       map_w     = cfg_data;
                    default: ;
                endcase
            end

            // compare each result with the oldest expectation
            if (m_tvalid && m_tready) begin
                result_count = result_count + 1;
                if (pooled_q.size() == 0) begin
                    report_mismatch("unexpected result", m_tdata, '0);
                end else begin
                    want = pooled_q.pop_front();
                    // any NaN pattern is taken for a NaN average
                    if (!(is_nan16(want.value) && is_nan16(m_tdata[15:0])) &&
                        m_tdata[15:0] !== want.value)
                        report_mismatch("pooled", m_tdata[15:0], want.value);
                    if (m_tdata[23:16] !== want.row)
                        report_mismatch("out_row", m_tdata[23:16], want.row);
                    if (m_tdata[31:24] !== want.col)
                        report_mismatch("out_col", m_tdata[31:24], want.col);
                    if (m_tuser !== want.empty)
                        report_mismatch("empty_window", m_tuser, want.empty);
                    if (m_tlast !== want.last)
                        report_mismatch("last_output", m_tlast, want.last);
                end
            end

            if (s_tvalid && s_tready) pool_pixel(s_tdata, s_tuser, s_tlast);
        end
        waiting <= pooled_q.size();
    end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the window pooling unit: directed maps with special fp16
// values, then random maps under changing settings and idle patterns, with
// a long receiver hold-off and a full drain mid-map. Checking is done by
// pool_checker.
// ----------------------------------------------------------------------------
module tb;
    import wpf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  ITEMS_PER_PHASE = 150;
    localparam int  SETTLE          = 300;
    localparam longint CYCLE_LIMIT  = 4000000;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = REG_POOL_KIND;
    logic [8:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    int     fail_count;
    int     waiting;
    int     result_count;
    int     sent_count = 0;
    int     idle_pct   = 0;
    int     stall_pct  = 0;
    int     hold_req   = 0;
    int     hold_seen  = 0;
    int     hold_left  = 0;
    longint cycles     = 0;

    always #1 aclk = ~aclk;

    window_pooling_fp16_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    pool_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .waiting      (waiting),
        .result_count (result_count)
    );

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", waiting);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // result side: random stalls, plus a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = 500;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // one pixel request, with random idle cycles ahead of it
    task automatic send_pixel(input logic [15:0] pix, input logic pad, input logic at_end);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= pad;
        s_tlast  <= at_end;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // stop sending until every expected result is back and the unit is quiet
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (waiting != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 9'(val);
        @(posedge aclk);
    endtask

    task automatic set_config(input int kind, input int glob, input int excl, input int kw,
                              input int kh, input int sx, input int sy, input int mw);
        drain_results();
        write_reg(REG_POOL_KIND, kind);
        write_reg(REG_GLOBAL_MODE, glob);
        write_reg(REG_EXCLUDE_PAD, excl);
        write_reg(REG_WIN_W, kw);
        write_reg(REG_WIN_H, kh);
        write_reg(REG_STEP_X, sx);
        write_reg(REG_STEP_Y, sy);
        write_reg(REG_MAP_W, mw);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // mostly moderate values, some fully random patterns and special values
    function automatic logic [15:0] rand_pixel();
        logic [15:0] specials [12] = '{16'h7C00, 16'hFC00, 16'h7E00, 16'h7C01, 16'hFE00,
                                       16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h7BFF,
                                       16'hFBFF, 16'h0400};
        int pick;
        pick = $urandom_range(19);
        if (pick == 0) return 16'($urandom);
        if (pick == 1) return specials[$urandom_range(11)];
        return {1'($urandom), 5'($urandom_range(10, 20)), 10'($urandom)};
    endfunction

    function automatic int rand_window();
        int pick;
        pick = $urandom_range(19);
        if (pick == 0) return 0;
        if (pick == 1) return 15;
        if (pick == 2) return 8;
        return $urandom_range(1, 4);
    endfunction

    // a padded map in raster order, possibly cut short
    task automatic send_map(input int w, input int h, input int border, input int cut,
                            input bit pause_mid);
        int  r;
        int  c;
        bit  pad;
        for (int n = 0; n < cut; n++) begin
            r   = n / w;
            c   = n % w;
            pad = (r < border) || (r >= h - border) || (c < border) || (c >= w - border);
            if (pause_mid && n == cut / 2) drain_results();
            send_pixel(rand_pixel(), pad, n == cut - 1);
        end
    endtask

    task automatic random_map(input bit pause_mid);
        int kw;
        int kh;
        int kwe;
        int khe;
        int sx;
        int sy;
        int mw;
        int h;
        int cut;
        kw  = rand_window();
        kh  = rand_window();
        kwe = (kw == 0) ? 1 : (kw > MAX_WINDOW ? MAX_WINDOW : kw);
        khe = (kh == 0) ? 1 : (kh > MAX_WINDOW ? MAX_WINDOW : kh);
        sx  = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 3);
        sy  = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(1, 3);
        mw  = kwe + $urandom_range(0, 5);
        h   = khe + $urandom_range(0, 4);
        cut = ($urandom_range(9) == 0) ? $urandom_range(1, mw * h) : mw * h;
        set_config($urandom_range(1), $urandom_range(99) < 12, $urandom_range(1),
                   kw, kh, sx, sy, mw);
        send_map(mw, h, $urandom_range(0, 2), cut, pause_mid);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: window wider than the one-pixel map never completes
        send_pixel(16'h3C00, 1'b0, 1'b0);
        send_pixel(16'hBC00, 1'b1, 1'b0);
        send_pixel(16'h4000, 1'b0, 1'b1);

        // max over NaN, infinities, signed zeros and subnormals
        set_config(0, 0, 0, 2, 2, 2, 2, 4);
        send_pixel(16'h7E00, 1'b0, 1'b0);
        send_pixel(16'h8000, 1'b0, 1'b0);
        send_pixel(16'hFC00, 1'b0, 1'b0);
        send_pixel(16'h0001, 1'b0, 1'b0);
        send_pixel(16'h7E00, 1'b0, 1'b0);
        send_pixel(16'h0000, 1'b0, 1'b0);
        send_pixel(16'hFBFF, 1'b0, 1'b0);
        send_pixel(16'h7C00, 1'b0, 1'b1);

        // average excluding padding over an all-padding window
        set_config(1, 0, 1, 2, 2, 2, 2, 2);
        send_pixel(16'h3C00, 1'b1, 1'b0);
        send_pixel(16'h7BFF, 1'b1, 1'b0);
        send_pixel(16'h7BFF, 1'b1, 1'b0);
        send_pixel(16'h4400, 1'b1, 1'b1);

        // whole-map average
        set_config(1, 1, 1, 8, 8, 8, 8, 3);
        send_pixel(16'h7BFF, 1'b0, 1'b0);
        send_pixel(16'h7BFF, 1'b1, 1'b0);
        send_pixel(16'h03FF, 1'b0, 1'b1);

        // zero sizes act as one, an oversized map width acts as the maximum
        set_config(1, 0, 0, 0, 0, 0, 0, 511);
        send_pixel(16'h3555, 1'b0, 1'b0);
        send_pixel(16'hC000, 1'b1, 1'b0);
        send_pixel(16'h0400, 1'b0, 1'b1);

        // random maps over four idle patterns
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct  = (ph == 1) ? 74 : (ph == 3 ? 24 : 0);
            stall_pct = (ph == 2) ? 74 : (ph == 3 ? 24 : 0);
            if (ph == 2) begin
                // dense one-pixel windows while the receiver holds off
                set_config(0, 0, 0, 1, 1, 1, 1, 6);
                hold_req++;
                send_map(6, 4, 1, 24, 1'b0);
            end
            while (sent_count < ITEMS_PER_PHASE * (ph + 1) + 21)
                random_map(ph == 3 && sent_count < ITEMS_PER_PHASE * 3 + 40);
        end

        drain_results();
        $display("sent %0d pixel requests and checked %0d pooled results", sent_count,
                 result_count);
        $display("covered max, average, padding exclusion, whole-map mode and stalls");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/wpf_pkg.sv
rtl/wpf_line_store.sv
rtl/wpf_fp32_add.sv
rtl/wpf_fp32_div.sv
rtl/window_pooling_fp16_unit.sv
tb/sv/pool_checker.sv
tb/sv/tb.sv
